[hdl/sea_pkg.sv]
// Shared types, codes and step tables for the stepper / encoder axis counter.
package sea_pkg;

    localparam int GROUPS_DEFAULT        = 4;
    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int MODE_REGS             = 4;
    localparam int CFG_INDEX_W           = 3;
    localparam int CFG_DATA_W            = 4;

    // Item operation codes.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // Group mode codes.
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_INPUT  = 2'd1;
    localparam logic [1:0] MODE_OUTPUT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MODE_GROUP0      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_LINKED_MASK = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         group;
        logic               home_level;
        logic signed [31:0] target;
        logic               enc_a;
        logic               enc_b;
        logic signed [31:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic               coil_a;
        logic               coil_b;
        logic signed [31:0] position;
        logic               homed;
        logic               home_event;
    } out_item_t;

    // Control view of one item as seen by the per-group update logic.
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] mode;
        logic       linked;
        logic       home_level;
        logic       enc_a;
        logic       enc_b;
    } axis_ctl_t;

    // Coil levels per phase, bit 0 is coil_a and bit 1 is coil_b.
    function automatic logic [1:0] fwd_coils(input logic [1:0] ph);
        logic [1:0] c;
        case (ph)
            2'd0:    c = 2'b11;
            2'd1:    c = 2'b10;
            2'd2:    c = 2'b00;
            default: c = 2'b01;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] back_coils(input logic [1:0] ph);
        logic [1:0] c;
        case (ph)
            2'd0:    c = 2'b01;
            2'd1:    c = 2'b00;
            2'd2:    c = 2'b10;
            default: c = 2'b11;
        endcase
        return c;
    endfunction

endpackage

[hdl/sea_axis_step.sv]
// Next-state logic of one axis group for a single request.
module sea_axis_step
    import sea_pkg::*;
#(
    parameter int POS_W = POSITION_BITS_DEFAULT
) (
    input  axis_ctl_t                ctl,
    input  logic signed [31:0]       target,
    input  logic signed [31:0]       load_value,
    input  logic signed [POS_W-1:0]  pos,
    input  logic signed [POS_W-1:0]  setp,
    input  logic [1:0]               phase,
    input  logic                     homed,
    input  logic [1:0]               coils,
    output logic signed [POS_W-1:0]  pos_next,
    output logic signed [POS_W-1:0]  setp_next,
    output logic [1:0]               phase_next,
    output logic                     homed_next,
    output logic [1:0]               coils_next,
    output logic                     home_event
);

    logic signed [POS_W-1:0] tick_setp;
    logic signed [POS_W-1:0] tick_pos;
    logic                    tick_homed;
    logic signed [POS_W-1:0] target_ext;
    logic signed [POS_W-1:0] load_ext;

    assign target_ext = POS_W'(target);
    assign load_ext   = POS_W'(load_value);

    // The target is latched and the home switch looked at only at phase zero.
    always_comb begin
        tick_setp  = setp;
        tick_pos   = pos;
        tick_homed = homed;
        if (phase == 2'd0) begin
            tick_setp = target_ext;
            if (!ctl.home_level) begin
                if (!homed) begin
                    tick_homed = 1'b1;
                    tick_pos   = '0;
                    tick_setp  = '0;
                end
            end else begin
                tick_homed = 1'b0;
            end
        end
    end

    always_comb begin
        pos_next   = pos;
        setp_next  = setp;
        phase_next = phase;
        homed_next = homed;
        coils_next = coils;
        home_event = 1'b0;
        case (ctl.op)
            OP_TICK: begin
                if (ctl.mode == MODE_OUTPUT) begin
                    setp_next  = tick_setp;
                    pos_next   = tick_pos;
                    homed_next = tick_homed;
                    if (tick_setp != tick_pos) begin
                        coils_next = (tick_setp > tick_pos) ? fwd_coils(phase)
                                                            : back_coils(phase);
                        phase_next = phase + 2'd1;
                        // The position moves only when a full cycle completes.
                        if (phase == 2'd3) begin
                            pos_next = (tick_setp > tick_pos) ? tick_pos + POS_W'(1)
                                                              : tick_pos - POS_W'(1);
                        end
                    end
                end else if (ctl.mode == MODE_INPUT) begin
                    if (ctl.home_level) begin
                        homed_next = 1'b0;
                    end else if (!homed) begin
                        homed_next = 1'b1;
                        if (ctl.linked) begin
                            home_event = 1'b1;
                        end else begin
                            pos_next  = '0;
                            setp_next = '0;
                        end
                    end
                end
            end
            OP_EDGE: begin
                if (ctl.mode == MODE_INPUT) begin
                    pos_next = (ctl.enc_a == ctl.enc_b) ? pos + POS_W'(1)
                                                        : pos - POS_W'(1);
                end
            end
            OP_LOAD: begin
                pos_next = load_ext;
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/stepper_encoder_axis_counter_top.sv]
// Top level of the stepper / encoder axis counter with its group state and handshakes.
//
// Takes one request per clock cycle unless stalled and returns one result per request.
// A request is held in an input register; in the cycle it advances, the addressed group's
// state is read, updated by one pass of short logic and written back, and the result is
// loaded into the output register. Because the group state is written in the same cycle
// it is read, a following request to the same group sees the updated state with no
// stall. The result side stalls the input side only when both registers are full.
// Configuration writes are accepted in every cycle and must be issued only while no
// request is in flight. No clearing pass is needed after reset.
module stepper_encoder_axis_counter_top
    import sea_pkg::*;
#(
    parameter int GROUPS        = GROUPS_DEFAULT,
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int GRP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    logic signed [POSITION_BITS-1:0] pos_reg   [GROUPS];
    logic signed [POSITION_BITS-1:0] setp_reg  [GROUPS];
    logic [1:0]                      phase_reg [GROUPS];
    logic                            homed_reg [GROUPS];
    logic [1:0]                      coils_reg [GROUPS];
    logic [1:0]                      mode_reg  [MODE_REGS];
    logic [MODE_REGS-1:0]            linked_reg;

    in_item_t  req_reg;
    logic      req_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;

    logic            advance;
    logic            hit;
    logic [GRP_W-1:0] sel;
    axis_ctl_t       ctl;

    logic signed [POSITION_BITS-1:0] pos_next;
    logic signed [POSITION_BITS-1:0] setp_next;
    logic [1:0]                      phase_next;
    logic                            homed_next;
    logic [1:0]                      coils_next;
    logic                            event_next;

    assign advance   = req_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !req_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    assign hit = (32'(req_reg.group) < GROUPS);
    assign sel = GRP_W'(req_reg.group);

    assign ctl.op         = req_reg.op;
    assign ctl.mode       = mode_reg[req_reg.group];
    assign ctl.linked     = linked_reg[req_reg.group];
    assign ctl.home_level = req_reg.home_level;
    assign ctl.enc_a      = req_reg.enc_a;
    assign ctl.enc_b      = req_reg.enc_b;

    sea_axis_step #(
        .POS_W (POSITION_BITS)
    ) u_step (
        .ctl        (ctl),
        .target     (req_reg.target),
        .load_value (req_reg.load_value),
        .pos        (pos_reg[sel]),
        .setp       (setp_reg[sel]),
        .phase      (phase_reg[sel]),
        .homed      (homed_reg[sel]),
        .coils      (coils_reg[sel]),
        .pos_next   (pos_next),
        .setp_next  (setp_next),
        .phase_next (phase_next),
        .homed_next (homed_next),
        .coils_next (coils_next),
        .home_event (event_next)
    );

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (advance) begin
            if (hit) begin
                out_reg.coil_a     <= coils_next[0];
                out_reg.coil_b     <= coils_next[1];
                out_reg.position   <= 32'(pos_next);
                out_reg.homed      <= homed_next;
                out_reg.home_event <= event_next;
            end else begin
                out_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                req_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < GROUPS; g++) begin
                pos_reg[g]   <= '0;
                setp_reg[g]  <= '0;
                phase_reg[g] <= '0;
                homed_reg[g] <= 1'b0;
                coils_reg[g] <= '0;
            end
            for (int m = 0; m < MODE_REGS; m++) begin
                mode_reg[m] <= MODE_OFF;
            end
            linked_reg <= '0;
        end else begin
            for (int g = 0; g < GROUPS; g++) begin
                // A change of mode drops the homed state and the step sequence.
                if (cfg_valid && g < MODE_REGS && cfg_index == CFG_INDEX_W'(g)
                        && cfg_data[1:0] != mode_reg[g % MODE_REGS]) begin
                    homed_reg[g] <= 1'b0;
                    phase_reg[g] <= '0;
                    coils_reg[g] <= '0;
                end else if (advance && hit && sel == GRP_W'(g)) begin
                    pos_reg[g]   <= pos_next;
                    setp_reg[g]  <= setp_next;
                    phase_reg[g] <= phase_next;
                    homed_reg[g] <= homed_next;
                    coils_reg[g] <= coils_next;
                end
            end
            if (cfg_valid) begin
                for (int m = 0; m < MODE_REGS; m++) begin
                    if (cfg_index == REG_MODE_GROUP0 + CFG_INDEX_W'(m)) begin
                        mode_reg[m] <= cfg_data[1:0];
                    end
                end
                if (cfg_index == REG_LOOP_LINKED_MASK) begin
                    linked_reg <= cfg_data[MODE_REGS-1:0];
                end
            end
        end
    end

endmodule
